>>> rtl/core/nts_pkg.sv
package nts_pkg;

    localparam int MAX_NUM_DIGITS = 16;
    localparam int DIG_AW         = $clog2(MAX_NUM_DIGITS);
    localparam int CNT_W          = $clog2(MAX_NUM_DIGITS + 1);

    localparam logic [1:0] KIND_TOKEN = 2'd0;
    localparam logic [1:0] KIND_END   = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    localparam logic [2:0] CLS_IDENT = 3'd0;
    localparam logic [2:0] CLS_NUM   = 3'd1;
    localparam logic [2:0] CLS_BIN   = 3'd2;
    localparam logic [2:0] CLS_PUNCT = 3'd3;
    localparam logic [2:0] CLS_OPS   = 3'd4;

    localparam logic [1:0] SRC_NONE  = 2'd0;
    localparam logic [1:0] SRC_PORT  = 2'd1;
    localparam logic [1:0] SRC_SAVED = 2'd2;
    localparam logic [1:0] SRC_DIGIT = 2'd3;

    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_APOS   = 8'h27;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_EQUAL  = 8'h3D;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_Z   = 8'h5A;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_LO_A   = 8'h61;
    localparam logic [7:0] CH_LO_B   = 8'h62;
    localparam logic [7:0] CH_LO_Z   = 8'h7A;
    localparam logic [7:0] CH_BAR    = 8'h7C;
    localparam logic [7:0] CH_TILDE  = 8'h7E;

    localparam logic [3:0] DIGIT_HI = 4'h3;

    typedef struct packed {
        logic eoi;
        logic digit;
        logic alpha;
        logic under;
        logic space;
        logic op;
        logic punct;
        logic apos;
        logic bee;
    } char_flags_t;

    typedef struct packed {
        char_flags_t in_flags;
        char_flags_t saved_flags;
        logic        count_full;
        logic        flush_last;
        logic        out_free;
    } nts_status_t;

    typedef struct packed {
        logic       save_in;
        logic       dig_wr;
        logic       cnt_clr;
        logic       rd_first;
        logic       rd_next;
        logic       out_load;
        logic [1:0] out_kind;
        logic [1:0] out_src;
        logic       out_start;
        logic [2:0] out_class;
        logic       out_last;
    } nts_cmd_t;

endpackage

>>> rtl/core/nts_ram.sv
module nts_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/core/nts_dpath.sv
module nts_dpath (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [7:0]          char_in,
    input  logic                end_of_input,
    input  logic                result_stall,
    input  nts_pkg::nts_cmd_t   cmd,
    output nts_pkg::nts_status_t st,
    output logic                result_valid,
    output logic [1:0]          result_kind,
    output logic [7:0]          token_char,
    output logic                token_start,
    output logic [2:0]          token_class,
    output logic                last_of_run
);

    import nts_pkg::*;

    function automatic char_flags_t classify(input logic [7:0] c, input logic e);
        char_flags_t f;
        f.eoi   = e;
        f.digit = !e && (c >= CH_ZERO) && (c <= CH_NINE);
        f.alpha = !e && (((c >= CH_UP_A) && (c <= CH_UP_Z)) ||
                         ((c >= CH_LO_A) && (c <= CH_LO_Z)));
        f.under = !e && (c == CH_UNDER);
        f.space = !e && ((c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR)));
        f.op    = !e && ((c == CH_AMP) || (c == CH_BAR) || (c == CH_CARET) ||
                         (c == CH_TILDE));
        f.punct = !e && ((c == CH_COMMA) || (c == CH_SEMI) || (c == CH_COLON) ||
                         (c == CH_LPAREN) || (c == CH_RPAREN) || (c == CH_EQUAL) ||
                         (c == CH_LBRACK) || (c == CH_RBRACK) || (c == CH_HASH) ||
                         (c == CH_DOT));
        f.apos  = !e && (c == CH_APOS);
        f.bee   = !e && (c == CH_LO_B);
        return f;
    endfunction

    logic [7:0]        char_reg;
    logic              eoi_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [DIG_AW-1:0] idx_reg;
    logic [DIG_AW-1:0] idx_next;
    logic [DIG_AW-1:0] rd_addr;
    logic              rd_en;
    logic [3:0]        rd_data;

    logic              valid_reg;
    logic [1:0]        kind_reg;
    logic [7:0]        char_out_reg;
    logic              start_reg;
    logic [2:0]        class_reg;
    logic              last_reg;
    logic [7:0]        char_sel;
    logic              start_sel;

    assign rd_en   = cmd.rd_first || cmd.rd_next;
    assign rd_addr = cmd.rd_first ? '0 : idx_reg + DIG_AW'(1);

    nts_ram #(
        .WIDTH (4),
        .DEPTH (MAX_NUM_DIGITS)
    ) u_digits (
        .clk     (clk),
        .wr_en   (cmd.dig_wr),
        .wr_addr (count_reg[DIG_AW-1:0]),
        .wr_data (char_in[3:0]),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        count_next = count_reg;
        if (cmd.cnt_clr)
        begin
            count_next = '0;
        end
        else if (cmd.dig_wr)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        idx_next = idx_reg;
        if (cmd.rd_first)
        begin
            idx_next = '0;
        end
        else if (cmd.rd_next)
        begin
            idx_next = idx_reg + DIG_AW'(1);
        end
    end

    always_comb
    begin
        unique case (cmd.out_src)
            SRC_PORT:  char_sel = char_in;
            SRC_SAVED: char_sel = char_reg;
            SRC_DIGIT: char_sel = {DIGIT_HI, rd_data};
            default:   char_sel = '0;
        endcase
        start_sel = (cmd.out_src == SRC_DIGIT) ? (idx_reg == '0) : cmd.out_start;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            idx_reg   <= idx_next;
            if (cmd.out_load)
            begin
                valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.save_in)
        begin
            char_reg <= char_in;
            eoi_reg  <= end_of_input;
        end
        if (cmd.out_load)
        begin
            kind_reg     <= cmd.out_kind;
            char_out_reg <= char_sel;
            start_reg    <= start_sel;
            class_reg    <= cmd.out_class;
            last_reg     <= cmd.out_last;
        end
    end

    assign st.in_flags    = classify(char_in, end_of_input);
    assign st.saved_flags = classify(char_reg, eoi_reg);
    assign st.count_full  = (count_reg >= CNT_W'(MAX_NUM_DIGITS));
    assign st.flush_last  = ((CNT_W'(idx_reg) + CNT_W'(1)) == count_reg);
    assign st.out_free    = !valid_reg || !result_stall;

    assign result_valid = valid_reg;
    assign result_kind  = kind_reg;
    assign token_char   = char_out_reg;
    assign token_start  = start_reg;
    assign token_class  = class_reg;
    assign last_of_run  = last_reg;

endmodule

>>> rtl/core/nts_ctrl.sv
module nts_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    input  nts_pkg::nts_status_t st,
    output nts_pkg::nts_cmd_t    cmd,
    output logic                 item_stall
);

    import nts_pkg::*;

    localparam logic [1:0] S_RUN  = 2'd0;
    localparam logic [1:0] S_FWR  = 2'd1;
    localparam logic [1:0] S_TAIL = 2'd2;

    localparam logic [2:0] M_IDLE  = 3'd0;
    localparam logic [2:0] M_IDENT = 3'd1;
    localparam logic [2:0] M_NUM   = 3'd2;
    localparam logic [2:0] M_OPS   = 3'd3;
    localparam logic [2:0] M_APOS  = 3'd4;
    localparam logic [2:0] M_BTICK = 3'd5;
    localparam logic [2:0] M_ERR   = 3'd6;

    typedef struct packed {
        logic       emit;
        logic [1:0] kind;
        logic       start;
        logic [2:0] cls;
        logic [2:0] mode;
        logic       dig_wr;
        logic       cnt_clr;
    } idle_act_t;

    // handling of a character seen between tokens
    function automatic idle_act_t idle_action(input char_flags_t f);
        idle_act_t a;
        a = '0;
        a.kind = KIND_TOKEN;
        a.mode = M_IDLE;
        priority if (f.eoi)
        begin
            a.emit    = 1'b1;
            a.kind    = KIND_END;
            a.cnt_clr = 1'b1;
        end
        else if (f.space)
        begin
            a.emit = 1'b0;
        end
        else if (f.digit)
        begin
            a.dig_wr = 1'b1;
            a.mode   = M_NUM;
        end
        else if (f.alpha || f.under)
        begin
            a.emit  = 1'b1;
            a.start = 1'b1;
            a.cls   = CLS_IDENT;
            a.mode  = M_IDENT;
        end
        else if (f.punct)
        begin
            a.emit  = 1'b1;
            a.start = 1'b1;
            a.cls   = CLS_PUNCT;
        end
        else if (f.op)
        begin
            a.emit  = 1'b1;
            a.start = 1'b1;
            a.cls   = CLS_OPS;
            a.mode  = M_OPS;
        end
        else
        begin
            a.emit    = 1'b1;
            a.kind    = KIND_ERROR;
            a.cnt_clr = 1'b1;
            a.mode    = M_ERR;
        end
        return a;
    endfunction

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic [2:0] mode_reg;
    logic [2:0] mode_next;
    idle_act_t  act;
    logic       act_saved;
    logic       take_idle;
    logic       go_error;
    logic       emit_char;
    logic [2:0] emit_class;
    logic       accept;
    logic       tail_emits;
    char_flags_t fi;

    assign fi         = st.in_flags;
    assign item_stall = (state_reg != S_RUN) || !st.out_free;
    assign accept     = item_valid && !item_stall;
    assign tail_emits = st.saved_flags.eoi || !st.saved_flags.space;
    assign act_saved  = (state_reg == S_TAIL);
    assign act        = idle_action(act_saved ? st.saved_flags : st.in_flags);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        mode_next  = mode_reg;
        take_idle  = 1'b0;
        go_error   = 1'b0;
        emit_char  = 1'b0;
        emit_class = CLS_IDENT;

        unique case (state_reg)
            S_RUN:
            begin
                if (accept)
                begin
                    unique case (mode_reg)
                        M_ERR:
                        begin
                            go_error = 1'b1;
                        end
                        M_NUM:
                        begin
                            if (fi.apos)
                            begin
                                mode_next = M_APOS;
                            end
                            else if (fi.digit)
                            begin
                                if (st.count_full)
                                begin
                                    go_error = 1'b1;
                                end
                                else
                                begin
                                    cmd.dig_wr = 1'b1;
                                end
                            end
                            else
                            begin
                                cmd.save_in  = 1'b1;
                                cmd.rd_first = 1'b1;
                                mode_next    = M_IDLE;
                                state_next   = S_FWR;
                            end
                        end
                        M_APOS:
                        begin
                            if (fi.bee)
                            begin
                                mode_next = M_BTICK;
                            end
                            else
                            begin
                                go_error = 1'b1;
                            end
                        end
                        M_BTICK:
                        begin
                            if (fi.digit)
                            begin
                                cmd.cnt_clr   = 1'b1;
                                emit_char     = 1'b1;
                                emit_class    = CLS_BIN;
                                cmd.out_start = 1'b1;
                                mode_next     = M_IDLE;
                            end
                            else
                            begin
                                go_error = 1'b1;
                            end
                        end
                        M_IDENT:
                        begin
                            if (fi.alpha || fi.digit || fi.under)
                            begin
                                emit_char  = 1'b1;
                                emit_class = CLS_IDENT;
                            end
                            else
                            begin
                                take_idle = 1'b1;
                            end
                        end
                        M_OPS:
                        begin
                            if (fi.op)
                            begin
                                emit_char  = 1'b1;
                                emit_class = CLS_OPS;
                            end
                            else
                            begin
                                take_idle = 1'b1;
                            end
                        end
                        default:
                        begin
                            take_idle = 1'b1;
                        end
                    endcase
                end
            end
            S_FWR:
            begin
                if (st.out_free)
                begin
                    cmd.out_load  = 1'b1;
                    cmd.out_kind  = KIND_TOKEN;
                    cmd.out_src   = SRC_DIGIT;
                    cmd.out_class = CLS_NUM;
                    cmd.out_last  = st.flush_last && !tail_emits;
                    if (st.flush_last)
                    begin
                        cmd.cnt_clr = 1'b1;
                        state_next  = tail_emits ? S_TAIL : S_RUN;
                    end
                    else
                    begin
                        cmd.rd_next = 1'b1;
                    end
                end
            end
            S_TAIL:
            begin
                if (st.out_free)
                begin
                    take_idle  = 1'b1;
                    state_next = S_RUN;
                end
            end
            default:
            begin
                state_next = S_RUN;
            end
        endcase

        if (take_idle)
        begin
            cmd.out_load  = act.emit;
            cmd.out_kind  = act.kind;
            cmd.out_src   = (act.kind != KIND_TOKEN) ? SRC_NONE :
                            (act_saved ? SRC_SAVED : SRC_PORT);
            cmd.out_start = act.start;
            cmd.out_class = act.cls;
            cmd.out_last  = 1'b1;
            cmd.dig_wr    = act.dig_wr && !act_saved;
            cmd.cnt_clr   = act.cnt_clr;
            mode_next     = act.mode;
        end

        if (emit_char)
        begin
            cmd.out_load  = 1'b1;
            cmd.out_kind  = KIND_TOKEN;
            cmd.out_src   = SRC_PORT;
            cmd.out_class = emit_class;
            cmd.out_last  = 1'b1;
        end

        if (go_error)
        begin
            cmd.out_load  = 1'b1;
            cmd.out_kind  = KIND_ERROR;
            cmd.out_src   = SRC_NONE;
            cmd.out_start = 1'b0;
            cmd.out_class = CLS_IDENT;
            cmd.out_last  = 1'b1;
            cmd.cnt_clr   = 1'b1;
            mode_next     = M_ERR;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_RUN;
            mode_reg  <= M_IDLE;
        end
        else
        begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
        end
    end

endmodule

>>> rtl/core/netlist_token_scanner_unit.sv
// Each result is registered; a result that a word gives directly appears in the cycle
// after the word is accepted. One word per cycle is taken while each word gives at most
// one result and result_stall is low. A number ending reads its n held digits from the
// digit RAM and flushes them one per cycle, holding on result_stall, then any closing result.
// Reset (rst_n, async, active low) returns to between tokens with no held digits
// and no pending result; the digit RAM itself is not cleared.
module netlist_token_scanner_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_stall,
    input  logic [7:0] char_in,
    input  logic       end_of_input,
    output logic       result_valid,
    input  logic       result_stall,
    output logic [1:0] result_kind,
    output logic [7:0] token_char,
    output logic       token_start,
    output logic [2:0] token_class,
    output logic       last_of_run
);

    import nts_pkg::*;

    nts_cmd_t    cmd;
    nts_status_t st;

    nts_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .st         (st),
        .cmd        (cmd),
        .item_stall (item_stall)
    );

    nts_dpath u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .char_in      (char_in),
        .end_of_input (end_of_input),
        .result_stall (result_stall),
        .cmd          (cmd),
        .st           (st),
        .result_valid (result_valid),
        .result_kind  (result_kind),
        .token_char   (token_char),
        .token_start  (token_start),
        .token_class  (token_class),
        .last_of_run  (last_of_run)
    );

endmodule

>>> sim/netlist_token_scanner_unit_tb.sv
module netlist_token_scanner_unit_tb;
    import nts_pkg::*;

    localparam int QUIET_LIMIT  = 2000;
    localparam int RANDOM_WORDS = 180;

    typedef enum logic [2:0] {
        SCAN_IDLE,
        SCAN_IDENT,
        SCAN_NUM,
        SCAN_OPS,
        SCAN_APOS,
        SCAN_BTICK,
        SCAN_ERR
    } scan_mode_e;

    typedef enum {
        PIECE_IDENT,
        PIECE_NUMBER,
        PIECE_BINARY,
        PIECE_PUNCT,
        PIECE_OPS,
        PIECE_SPACE,
        PIECE_END,
        PIECE_NOISE
    } piece_e;

    typedef enum {
        FAULT_BAD_CHAR,
        FAULT_APOS,
        FAULT_BTICK,
        FAULT_OVERFLOW
    } fault_e;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_SPARSE,
        STALL_MASK,
        STALL_HEAVY
    } stall_style_e;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] ch;
        logic       start;
        logic [2:0] cls;
        logic       last;
    } token_word_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       eoi;
        logic       typed;
        logic [1:0] kind;
        logic [7:0] tch;
        logic       start;
        logic [2:0] cls;
    } stim_row_t;

    localparam logic [7:0] PUNCT_CHARS [10] = '{CH_COMMA, CH_SEMI, CH_COLON, CH_LPAREN,
        CH_RPAREN, CH_EQUAL, CH_LBRACK, CH_RBRACK, CH_HASH, CH_DOT};
    localparam logic [7:0] OP_CHARS [4] = '{CH_AMP, CH_BAR, CH_CARET, CH_TILDE};

    // text with no faults; typed rows are single-result words
    localparam stim_row_t INTRO_ROWS [25] = '{
        '{CH_UP_A,          1'b0, 1'b1, KIND_TOKEN, CH_UP_A,   1'b1, CLS_IDENT},
        '{CH_LO_Z,          1'b0, 1'b0, KIND_TOKEN, 8'h00,     1'b0, CLS_IDENT},
        '{CH_UNDER,         1'b0, 1'b0, KIND_TOKEN, 8'h00,     1'b0, CLS_IDENT},
        '{CH_NINE,          1'b0, 1'b0, KIND_TOKEN, 8'h00,     1'b0, CLS_IDENT},
        '{CH_SPACE,         1'b0, 1'b0, KIND_TOKEN, 8'h00,     1'b0, CLS_IDENT},
        '{CH_UNDER,         1'b0, 1'b1, KIND_TOKEN, CH_UNDER,  1'b1, CLS_IDENT},
        '{CH_TAB,           1'b0, 1'b0, KIND_TOKEN, 8'h00,     1'b0, CLS_IDENT},
        '{CH_ZERO,          1'b0, 1'b0, KIND_TOKEN, 8'h00,     1'b0, CLS_IDENT},
        '{CH_NINE,          1'b0, 1'b0, KIND_TOKEN, 8'h00,     1'b0, CLS_IDENT},
        '{CH_COMMA,         1'b0, 1'b0, KIND_TOKEN, 8'h00,     1'b0, CLS_IDENT},
        '{CH_BAR,           1'b0, 1'b1, KIND_TOKEN, CH_BAR,    1'b1, CLS_OPS},
        '{CH_AMP,           1'b0, 1'b0, KIND_TOKEN, 8'h00,     1'b0, CLS_IDENT},
        '{CH_CARET,         1'b0, 1'b0, KIND_TOKEN, 8'h00,     1'b0, CLS_IDENT},
        '{CH_TILDE,         1'b0, 1'b0, KIND_TOKEN, 8'h00,     1'b0, CLS_IDENT},
        '{CH_LPAREN,        1'b0, 1'b1, KIND_TOKEN, CH_LPAREN, 1'b1, CLS_PUNCT},
        '{CH_CR,            1'b0, 1'b0, KIND_TOKEN, 8'h00,     1'b0, CLS_IDENT},
        '{CH_ZERO + 8'd1,   1'b0, 1'b0, KIND_TOKEN, 8'h00,     1'b0, CLS_IDENT},
        '{CH_APOS,          1'b0, 1'b0, KIND_TOKEN, 8'h00,     1'b0, CLS_IDENT},
        '{CH_LO_B,          1'b0, 1'b0, KIND_TOKEN, 8'h00,     1'b0, CLS_IDENT},
        '{CH_ZERO,          1'b0, 1'b1, KIND_TOKEN, CH_ZERO,   1'b1, CLS_BIN},
        '{CH_ZERO + 8'd7,   1'b0, 1'b0, KIND_TOKEN, 8'h00,     1'b0, CLS_IDENT},
        '{CH_LO_A,          1'b0, 1'b0, KIND_TOKEN, 8'h00,     1'b0, CLS_IDENT},
        '{CH_ZERO + 8'd5,   1'b0, 1'b0, KIND_TOKEN, 8'h00,     1'b0, CLS_IDENT},
        '{8'h80,            1'b1, 1'b0, KIND_TOKEN, 8'h00,     1'b0, CLS_IDENT},
        '{8'hFF,            1'b1, 1'b1, KIND_END,   8'h00,     1'b0, CLS_IDENT}
    };

    // after a fault everything reads back as an error
    localparam stim_row_t STICKY_ROWS [4] = '{
        '{8'h00,   1'b0, 1'b1, KIND_ERROR, 8'h00, 1'b0, CLS_IDENT},
        '{8'hFF,   1'b0, 1'b1, KIND_ERROR, 8'h00, 1'b0, CLS_IDENT},
        '{8'h00,   1'b1, 1'b1, KIND_ERROR, 8'h00, 1'b0, CLS_IDENT},
        '{CH_LO_A, 1'b0, 1'b1, KIND_ERROR, 8'h00, 1'b0, CLS_IDENT}
    };

    logic       clk          = 1'b0;
    logic       rst_n        = 1'b0;
    logic       item_valid   = 1'b0;
    logic       item_stall;
    logic [7:0] char_in      = 8'h00;
    logic       end_of_input = 1'b0;
    logic       result_valid;
    logic       result_stall = 1'b0;
    logic [1:0] result_kind;
    logic [7:0] token_char;
    logic       token_start;
    logic [2:0] token_class;
    logic       last_of_run;

    netlist_token_scanner_unit i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .char_in      (char_in),
        .end_of_input (end_of_input),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_kind  (result_kind),
        .token_char   (token_char),
        .token_start  (token_start),
        .token_class  (token_class),
        .last_of_run  (last_of_run)
    );

    always #10 clk = ~clk;

    scan_mode_e  scan_mode = SCAN_IDLE;
    logic [3:0]  held_digits [MAX_NUM_DIGITS];
    int          held_count = 0;
    token_word_t step_words [$];
    token_word_t expected_words [$];
    token_word_t seen_word;
    token_word_t due_word;

    int           words_sent   = 0;
    int           burst_left   = 0;
    int           bad_words    = 0;
    int           quiet_cycles = 0;
    int           stall_tick   = 0;
    stall_style_e stall_style  = STALL_NONE;
    logic [7:0]   stall_mask   = 8'h00;

    function automatic bit is_digit(input logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic bit is_word_lead(input logic [7:0] c);
        return (c >= CH_UP_A && c <= CH_UP_Z) || (c >= CH_LO_A && c <= CH_LO_Z) || c == CH_UNDER;
    endfunction

    function automatic bit is_space(input logic [7:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic bit is_op(input logic [7:0] c);
        return c inside {CH_AMP, CH_BAR, CH_CARET, CH_TILDE};
    endfunction

    function automatic bit is_punct(input logic [7:0] c);
        return c inside {CH_COMMA, CH_SEMI, CH_COLON, CH_LPAREN, CH_RPAREN,
                         CH_EQUAL, CH_LBRACK, CH_RBRACK, CH_HASH, CH_DOT};
    endfunction

    function automatic logic [7:0] random_ident_char(input bit lead);
        int r;
        r = $urandom_range(0, lead ? 52 : 62);
        if (r < 26)
            return CH_UP_A + 8'(r);
        else if (r < 52)
            return CH_LO_A + 8'(r - 26);
        else if (r == 52)
            return CH_UNDER;
        else
            return CH_ZERO + 8'(r - 53);
    endfunction

    function automatic logic [7:0] random_space_char();
        int r;
        r = $urandom_range(0, 5);
        return (r == 5) ? CH_SPACE : CH_TAB + 8'(r);
    endfunction

    function automatic void emit(input logic [1:0] kind, input logic [7:0] ch,
                                 input logic start, input logic [2:0] cls);
        token_word_t w;
        w = {kind, ch, start, cls, 1'b0};
        step_words.insert(step_words.size(), w);
    endfunction

    function automatic void flush_held();
        for (int i = 0; i < held_count; i++)
            emit(KIND_TOKEN, CH_ZERO | {4'h0, held_digits[i]}, i == 0, CLS_NUM);
        held_count = 0;
    endfunction

    function automatic void enter_error();
        held_count = 0;
        scan_mode  = SCAN_ERR;
        emit(KIND_ERROR, 8'h00, 1'b0, CLS_IDENT);
    endfunction

    // fills step_words with what one accepted word yields
    function automatic void scan_char(input logic [7:0] c, input logic eoi);
        bit to_idle;
        to_idle = 1'b0;
        step_words.delete();
        case (scan_mode)
            SCAN_ERR:
                emit(KIND_ERROR, 8'h00, 1'b0, CLS_IDENT);
            SCAN_NUM:
                if (!eoi && c == CH_APOS)
                    scan_mode = SCAN_APOS;
                else if (!eoi && is_digit(c))
                begin
                    if (held_count >= MAX_NUM_DIGITS)
                        enter_error();
                    else
                    begin
                        held_digits[held_count] = c[3:0];
                        held_count++;
                    end
                end
                else
                begin
                    flush_held();
                    to_idle = 1'b1;
                end
            SCAN_APOS:
                if (!eoi && c == CH_LO_B)
                    scan_mode = SCAN_BTICK;
                else
                    enter_error();
            SCAN_BTICK:
                if (!eoi && is_digit(c))
                begin
                    held_count = 0;
                    emit(KIND_TOKEN, c, 1'b1, CLS_BIN);
                    scan_mode = SCAN_IDLE;
                end
                else
                    enter_error();
            SCAN_IDENT:
                if (!eoi && (is_word_lead(c) || is_digit(c)))
                    emit(KIND_TOKEN, c, 1'b0, CLS_IDENT);
                else
                    to_idle = 1'b1;
            SCAN_OPS:
                if (!eoi && is_op(c))
                    emit(KIND_TOKEN, c, 1'b0, CLS_OPS);
                else
                    to_idle = 1'b1;
            default:
                to_idle = 1'b1;
        endcase

        if (to_idle)
        begin
            scan_mode = SCAN_IDLE;
            if (eoi)
            begin
                held_count = 0;
                emit(KIND_END, 8'h00, 1'b0, CLS_IDENT);
            end
            else if (is_space(c))
            begin
            end
            else if (is_digit(c))
            begin
                held_digits[0] = c[3:0];
                held_count     = 1;
                scan_mode      = SCAN_NUM;
            end
            else if (is_word_lead(c))
            begin
                emit(KIND_TOKEN, c, 1'b1, CLS_IDENT);
                scan_mode = SCAN_IDENT;
            end
            else if (is_punct(c))
                emit(KIND_TOKEN, c, 1'b1, CLS_PUNCT);
            else if (is_op(c))
            begin
                emit(KIND_TOKEN, c, 1'b1, CLS_OPS);
                scan_mode = SCAN_OPS;
            end
            else
                enter_error();
        end
    endfunction

    task automatic send_word(input logic [7:0] ch, input logic eoi, input bit typed,
                             input token_word_t typed_word);
        token_word_t w;
        item_valid   <= 1'b1;
        char_in      <= ch;
        end_of_input <= eoi;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        words_sent++;
        scan_char(ch, eoi);
        if (typed)
            expected_words.insert(expected_words.size(), typed_word);
        else
            foreach (step_words[i])
            begin
                w      = step_words[i];
                w.last = (i == step_words.size() - 1);
                expected_words.insert(expected_words.size(), w);
            end
        if (burst_left > 0)
            burst_left--;
        else
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 5))
                @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 8);
        end
    endtask

    task automatic send_char(input logic [7:0] ch);
        send_word(ch, 1'b0, 1'b0, '0);
    endtask

    task automatic send_end();
        send_word(8'($urandom_range(0, 255)), 1'b1, 1'b0, '0);
    endtask

    task automatic send_digits(input int count);
        repeat (count)
            send_char(CH_ZERO + 8'($urandom_range(0, 9)));
    endtask

    task automatic run_row(input stim_row_t row);
        send_word(row.ch, row.eoi, row.typed, {row.kind, row.tch, row.start, row.cls, 1'b1});
    endtask

    task automatic send_piece(input piece_e p);
        logic [7:0] c;
        case (p)
            PIECE_IDENT:
            begin
                send_char(random_ident_char(1'b1));
                repeat ($urandom_range(0, 6))
                    send_char(random_ident_char(1'b0));
            end
            PIECE_NUMBER:
                if ($urandom_range(0, 7) == 0)
                    send_digits($urandom_range(0, 1) ? MAX_NUM_DIGITS
                                                     : $urandom_range(5, MAX_NUM_DIGITS));
                else
                    send_digits($urandom_range(1, 4));
            PIECE_BINARY:
            begin
                send_digits($urandom_range(1, 3));
                send_char(CH_APOS);
                send_char(CH_LO_B);
                send_char(CH_ZERO + 8'($urandom_range(0, 9)));
            end
            PIECE_PUNCT:
                send_char(PUNCT_CHARS[$urandom_range(0, 9)]);
            PIECE_OPS:
                repeat ($urandom_range(1, 4))
                    send_char(OP_CHARS[$urandom_range(0, 3)]);
            PIECE_SPACE:
                repeat ($urandom_range(1, 3))
                    send_char(random_space_char());
            PIECE_END:
                send_end();
            default:
            begin
                do
                    c = 8'($urandom_range(0, 127));
                while (!(is_space(c) || is_word_lead(c) || is_punct(c) || is_op(c)));
                send_char(c);
            end
        endcase
    endtask

    initial
    begin
        int         r;
        piece_e     p;
        bit         need_gap;
        logic [7:0] c;
        fault_e     fault;

        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (INTRO_ROWS[i])
            run_row(INTRO_ROWS[i]);

        // mostly well-formed text; numbers never run into a following number
        need_gap = 1'b0;
        while (words_sent < $size(INTRO_ROWS) + RANDOM_WORDS)
        begin
            r = $urandom_range(0, 99);
            if (r < 25)
                p = PIECE_IDENT;
            else if (r < 45)
                p = PIECE_NUMBER;
            else if (r < 55)
                p = PIECE_BINARY;
            else if (r < 67)
                p = PIECE_PUNCT;
            else if (r < 77)
                p = PIECE_OPS;
            else if (r < 90)
                p = PIECE_SPACE;
            else if (r < 94)
                p = PIECE_END;
            else
                p = PIECE_NOISE;
            if (need_gap && (p == PIECE_NUMBER || p == PIECE_BINARY))
                send_char(CH_SPACE);
            send_piece(p);
            need_gap = (p == PIECE_IDENT || p == PIECE_NUMBER || p == PIECE_NOISE);
        end

        // one fault, since errors hold until reset
        send_char(CH_SPACE);
        fault = fault_e'($urandom_range(0, 3));
        case (fault)
            FAULT_BAD_CHAR:
            begin
                do
                    c = 8'($urandom_range(0, 255));
                while (is_space(c) || is_digit(c) || is_word_lead(c) || is_punct(c) || is_op(c));
                send_char(c);
            end
            FAULT_APOS:
            begin
                send_digits($urandom_range(1, 3));
                send_char(CH_APOS);
                if ($urandom_range(0, 2) == 0)
                    send_end();
                else
                begin
                    do
                        c = 8'($urandom_range(0, 255));
                    while (c == CH_LO_B);
                    send_char(c);
                end
            end
            FAULT_BTICK:
            begin
                send_digits($urandom_range(1, 3));
                send_char(CH_APOS);
                send_char(CH_LO_B);
                if ($urandom_range(0, 2) == 0)
                    send_end();
                else
                begin
                    do
                        c = 8'($urandom_range(0, 255));
                    while (is_digit(c));
                    send_char(c);
                end
            end
            default:
                send_digits(MAX_NUM_DIGITS + 1);
        endcase

        foreach (STICKY_ROWS[i])
            run_row(STICKY_ROWS[i]);
        repeat (8)
            send_char(8'($urandom_range(0, 255)));
        item_valid <= 1'b0;

        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (40)
            @(posedge clk);
        if (bad_words == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            seen_word = {result_kind, token_char, token_start, token_class, last_of_run};
            if (expected_words.size() == 0)
            begin
                if (bad_words < 10)
                    $display("unexpected word: kind %0d char %02h start %0d class %0d last %0d",
                             seen_word.kind, seen_word.ch, seen_word.start, seen_word.cls,
                             seen_word.last);
                bad_words++;
            end
            else
            begin
                due_word = expected_words.pop_front();
                if (seen_word !== due_word)
                begin
                    if (bad_words < 10)
                    begin
                        $display("mismatch: want kind %0d char %02h start %0d class %0d last %0d",
                                 due_word.kind, due_word.ch, due_word.start, due_word.cls,
                                 due_word.last);
                        $display("          got  kind %0d char %02h start %0d class %0d last %0d",
                                 seen_word.kind, seen_word.ch, seen_word.start, seen_word.cls,
                                 seen_word.last);
                    end
                    bad_words++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        stall_tick <= stall_tick + 1;
        if (stall_tick % 64 == 0)
        begin
            stall_style <= stall_style_e'($urandom_range(0, 3));
            stall_mask  <= 8'($urandom);
        end
        case (stall_style)
            STALL_NONE:   result_stall <= 1'b0;
            STALL_SPARSE: result_stall <= ($urandom_range(0, 2) == 0);
            STALL_MASK:   result_stall <= stall_mask[stall_tick % 8];
            default:      result_stall <= ($urandom_range(0, 1) == 0);
        endcase
    end

    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && !item_stall) || (result_valid && !result_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

endmodule
